// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define OALE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define OALE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/oale_pkg.sv
// ----------------------------------------------------------------------------
// oale_pkg
// Types and constants of the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

	localparam int CAPACITY    = 256;
	localparam int ENTRY_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

	typedef enum logic [2:0] {
		K_APPEND = 3'd0,
		K_REMOVE = 3'd1,
		K_INSERT = 3'd2,
		K_ERASE  = 3'd3,
		K_FIND   = 3'd4,
		K_READ   = 3'd5,
		K_WRITE  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DRAIN,
		S_PUT,
		S_RDATA
	} state_t;

	typedef enum logic [1:0] {
		SC_INS,
		SC_ERA,
		SC_FIND
	} scan_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [8:0]         position;
		logic signed [31:0] operand_value;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_data;
		logic               found;
		logic [7:0]         found_position;
		logic [8:0]         entry_count;
	} out_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] next_idx;
		logic [IDX_W-1:0] tgt;
		logic             last;
		logic             eq;
	} step_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_sts_t;

endpackage

// File: src/oale_mem.sv
// ----------------------------------------------------------------------------
// oale_mem
// Entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oale_mem (
	input  logic                clk,
	input  oale_pkg::mem_req_t  req,
	output oale_pkg::entry_t    rd_data
);

	oale_pkg::entry_t mem_q [oale_pkg::CAPACITY];
	oale_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/oale_step.sv
// ----------------------------------------------------------------------------
// oale_step
// Shared scan unit: index step, write-back target, end test and compare.
// ----------------------------------------------------------------------------
module oale_step (
	input  oale_pkg::scan_t              mode,
	input  logic [oale_pkg::IDX_W-1:0]   idx,
	input  logic [oale_pkg::IDX_W-1:0]   bound,
	input  oale_pkg::entry_t             a,
	input  oale_pkg::entry_t             b,
	output oale_pkg::step_t              res
);

	localparam logic [oale_pkg::IDX_W-1:0] ONE = oale_pkg::IDX_W'(1);

	logic [oale_pkg::IDX_W-1:0] inc;
	logic [oale_pkg::IDX_W-1:0] dec;

	assign inc = idx + ONE;
	assign dec = idx - ONE;

	always_comb begin
		res.last = (idx == bound);
		res.eq   = (a == b);
		case (mode)
			oale_pkg::SC_INS: begin
				res.next_idx = dec;
				res.tgt      = inc;
			end
			oale_pkg::SC_ERA: begin
				res.next_idx = inc;
				res.tgt      = dec;
			end
			default: begin
				res.next_idx = inc;
				res.tgt      = idx;
			end
		endcase
	end

endmodule

// File: src/oale_ctrl.sv
// ----------------------------------------------------------------------------
// oale_ctrl
// Sequencer: decodes one operation, walks the store through the shared
// scan unit and builds the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oale_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  oale_pkg::in_t         item,
	input  oale_pkg::entry_t      rd_data,
	output oale_pkg::mem_req_t    mem_req,
	output oale_pkg::ctrl_sts_t   sts,
	output oale_pkg::out_t        res
);

	localparam logic [oale_pkg::CNT_W-1:0] CNT_ONE = oale_pkg::CNT_W'(1);
	localparam logic [oale_pkg::CNT_W-1:0] CNT_MAX = oale_pkg::CNT_W'(oale_pkg::CAPACITY);
	localparam logic [oale_pkg::IDX_W-1:0] IDX_ONE = oale_pkg::IDX_W'(1);

	oale_pkg::state_t             state_q, state_d;
	oale_pkg::in_t                op_q;
	logic [oale_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [oale_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic                         pend_q, pend_d;
	logic [oale_pkg::IDX_W-1:0]   pend_addr_q, pend_addr_d;
	logic                         done;

	oale_pkg::kind_t              kind;
	oale_pkg::scan_t              mode;
	oale_pkg::step_t              step;
	oale_pkg::entry_t             val;
	logic [oale_pkg::CNT_W-1:0]   pos9;
	logic [oale_pkg::IDX_W-1:0]   pos8;
	logic [oale_pkg::CNT_W-1:0]   cnt_m1;
	logic [oale_pkg::IDX_W-1:0]   bound;
	logic                         is_full;
	logic                         ins_bad;
	logic                         pos_bad;
	logic                         hit;

	assign kind    = oale_pkg::kind_t'(op_q.kind);
	assign val     = op_q.operand_value[oale_pkg::ENTRY_WIDTH-1:0];
	assign pos9    = op_q.position;
	assign pos8    = pos9[oale_pkg::IDX_W-1:0];
	assign cnt_m1  = cnt_q - CNT_ONE;
	assign is_full = (cnt_q == CNT_MAX);
	assign ins_bad = (pos9 > cnt_q);
	assign pos_bad = (pos9 >= cnt_q);
	assign hit     = pend_q && (kind == oale_pkg::K_FIND) && step.eq;

	always_comb begin
		unique case (kind)
			oale_pkg::K_INSERT: mode = oale_pkg::SC_INS;
			oale_pkg::K_ERASE:  mode = oale_pkg::SC_ERA;
			default:            mode = oale_pkg::SC_FIND;
		endcase
	end

	assign bound = (mode == oale_pkg::SC_INS) ? pos8 : cnt_m1[oale_pkg::IDX_W-1:0];

	oale_step u_step (
		.mode  (mode),
		.idx   (idx_q),
		.bound (bound),
		.a     (rd_data),
		.b     (val),
		.res   (step)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oale_pkg::S_IDLE: begin
				if (accept) state_d = oale_pkg::S_START;
			end
			oale_pkg::S_START: begin
				state_d = oale_pkg::S_IDLE;
				case (kind)
					oale_pkg::K_INSERT:
						if (!ins_bad && !is_full && pos9 != cnt_q) state_d = oale_pkg::S_SCAN;
					oale_pkg::K_ERASE:
						if (!pos_bad && pos9 != cnt_m1) state_d = oale_pkg::S_SCAN;
					oale_pkg::K_FIND:
						if (cnt_q != '0) state_d = oale_pkg::S_SCAN;
					oale_pkg::K_READ:
						if (!pos_bad) state_d = oale_pkg::S_RDATA;
					default: state_d = oale_pkg::S_IDLE;
				endcase
			end
			oale_pkg::S_SCAN: begin
				if (hit) state_d = oale_pkg::S_IDLE;
				else if (step.last) state_d = oale_pkg::S_DRAIN;
			end
			oale_pkg::S_DRAIN: begin
				state_d = (kind == oale_pkg::K_INSERT) ? oale_pkg::S_PUT : oale_pkg::S_IDLE;
			end
			oale_pkg::S_PUT:   state_d = oale_pkg::S_IDLE;
			oale_pkg::S_RDATA: state_d = oale_pkg::S_IDLE;
			default:           state_d = oale_pkg::S_IDLE;
		endcase
	end

	// datapath and result
	always_comb begin
		mem_req             = '0;
		mem_req.wr_data     = val;
		cnt_d               = cnt_q;
		idx_d               = idx_q;
		pend_d              = pend_q;
		pend_addr_d         = pend_addr_q;
		done                = 1'b0;
		res                 = '0;
		res.status          = oale_pkg::ST_OK;
		unique case (state_q)
			oale_pkg::S_IDLE: begin
				pend_d = 1'b0;
			end
			oale_pkg::S_START: begin
				done = 1'b1;
				case (kind)
					oale_pkg::K_APPEND: begin
						if (is_full) begin
							res.status = oale_pkg::ST_FULL;
						end else begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = cnt_q[oale_pkg::IDX_W-1:0];
							cnt_d           = cnt_q + CNT_ONE;
						end
					end
					oale_pkg::K_REMOVE: begin
						if (cnt_q != '0) cnt_d = cnt_m1;
					end
					oale_pkg::K_INSERT: begin
						if (ins_bad) begin
							res.status = oale_pkg::ST_RANGE;
						end else if (is_full) begin
							res.status = oale_pkg::ST_FULL;
						end else if (pos9 == cnt_q) begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = pos8;
							cnt_d           = cnt_q + CNT_ONE;
						end else begin
							done  = 1'b0;
							idx_d = cnt_m1[oale_pkg::IDX_W-1:0];
						end
					end
					oale_pkg::K_ERASE: begin
						if (pos_bad) begin
							res.status = oale_pkg::ST_RANGE;
						end else if (pos9 == cnt_m1) begin
							cnt_d = cnt_m1;
						end else begin
							done  = 1'b0;
							idx_d = pos8 + IDX_ONE;
						end
					end
					oale_pkg::K_FIND: begin
						if (cnt_q != '0) begin
							done  = 1'b0;
							idx_d = '0;
						end
					end
					oale_pkg::K_READ: begin
						if (pos_bad) begin
							res.status = oale_pkg::ST_RANGE;
						end else begin
							done            = 1'b0;
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = pos8;
						end
					end
					oale_pkg::K_WRITE: begin
						if (pos_bad) begin
							res.status = oale_pkg::ST_RANGE;
						end else begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = pos8;
						end
					end
					default: done = 1'b1;
				endcase
			end
			oale_pkg::S_SCAN: begin
				if (pend_q && kind != oale_pkg::K_FIND) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = pend_addr_q;
					mem_req.wr_data = rd_data;
				end
				if (hit) begin
					done               = 1'b1;
					pend_d             = 1'b0;
					res.found          = 1'b1;
					res.found_position = pend_addr_q;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = idx_q;
					pend_d          = 1'b1;
					pend_addr_d     = step.tgt;
					idx_d           = step.next_idx;
				end
			end
			oale_pkg::S_DRAIN: begin
				pend_d = 1'b0;
				if (kind != oale_pkg::K_FIND) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = pend_addr_q;
					mem_req.wr_data = rd_data;
				end
				if (kind == oale_pkg::K_ERASE) begin
					done  = 1'b1;
					cnt_d = cnt_m1;
				end else if (kind == oale_pkg::K_FIND) begin
					done = 1'b1;
					if (step.eq) begin
						res.found          = 1'b1;
						res.found_position = pend_addr_q;
					end
				end
			end
			oale_pkg::S_PUT: begin
				done            = 1'b1;
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = pos8;
				cnt_d           = cnt_q + CNT_ONE;
			end
			oale_pkg::S_RDATA: begin
				done          = 1'b1;
				res.read_data = 32'(rd_data);
			end
			default: done = 1'b0;
		endcase
		res.entry_count = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oale_pkg::S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item;
		end
		idx_q       <= idx_d;
		pend_addr_q <= pend_addr_d;
	end

	assign sts.idle = (state_q == oale_pkg::S_IDLE);
	assign sts.done = done;

	`OALE_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= CNT_MAX, "count above capacity")
	`OALE_ASSERT(a_done_idle, clk, arst_n, done |=> (state_q == oale_pkg::S_IDLE), "no return to idle after result")
	`OALE_ASSERT(a_pend_scan, clk, arst_n, pend_q |-> (state_q == oale_pkg::S_SCAN || state_q == oale_pkg::S_DRAIN), "pending write outside scan")
	`OALE_ASSERT(a_cnt_step, clk, arst_n, (state_q != oale_pkg::S_IDLE && !done) |=> $stable(cnt_q), "count moved mid operation")

endmodule

// File: src/ordered_array_list_engine_unit.sv
// Append, remove, write, insert at the end, erase of the last, full, bad positions and
// find on an empty list finish in the start state; read adds a state for the read data.
// Insert walks down from the last entry to the position, then drains and puts; erase walks
// up from the entry after the position, then drains. Find walks up from 0 to a match or the end.
// Throughput: next beat accepted the cycle after the result beat is taken.
// Reset: count cleared, list empty, no result pending; store contents not cleared.
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Ordered list of signed words with append, remove, insert, erase, find,
// read and write, one result beat per operation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_list_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  oale_pkg::in_t     in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output oale_pkg::out_t    out_data
);

	oale_pkg::mem_req_t    mem_req;
	oale_pkg::entry_t      rd_data;
	oale_pkg::ctrl_sts_t   sts;
	oale_pkg::out_t        res;
	oale_pkg::out_t        out_q;
	logic                  out_valid_q;
	logic                  accept;

	assign in_ready = sts.idle && !out_valid_q;
	assign accept   = in_valid && in_ready;

	oale_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (in_data),
		.rd_data (rd_data),
		.mem_req (mem_req),
		.sts     (sts),
		.res     (res)
	);

	oale_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`OALE_ASSERT(a_no_overwrite, clk, arst_n, sts.done |-> !out_valid_q, "result beat overwritten")
	`OALE_ASSERT_ALWAYS(a_rst_quiet, clk, $rose(arst_n) |-> !out_valid, "result beat out of reset")

endmodule
